// ===== rtl/k_way_max_merge_unit_defines.svh =====
// ----------------------------------------------------------------------------
// k_way_max_merge_unit_defines
// Assertion helpers for the merge unit.
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MAX_MERGE_UNIT_DEFINES_SVH
`define K_WAY_MAX_MERGE_UNIT_DEFINES_SVH

// same-cycle implication
`define KWMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwmm assertion failed");

// next-cycle implication
`define KWMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwmm assertion failed");

`endif

// ===== rtl/kwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwmm_pkg
// Widths and constants of the k-way max merge unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwmm_pkg;

  localparam int VAL_W  = 31;  // element / merged value width
  localparam int LIDX_W = 4;   // list index width on the ports
  localparam int CFG_W  = 5;   // active_lists register width
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  // word index of the registers (paddr[2])
  localparam logic REG_ACTIVE_LISTS = 1'b0;

endpackage

// ===== rtl/k_way_max_merge_unit.sv =====
// ----------------------------------------------------------------------------
// k_way_max_merge_unit
// Merges up to MAX_LISTS zero-terminated descending lists into one stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries the next element of one list (list index plus
//           value). A zero element marks the end of that list.
//   out_* : at most one result beat per input beat: the largest head and the
//           list to refill, a done beat when every active head is zero, or an
//           error beat for a supply to a full slot or an inactive list.
//   cfg_* : APB write/read of active_lists at byte address 0; write it only
//           while the unit is idle.
// Timing: heads live in a synchronous RAM. Once every active slot is filled,
//   a scan reads one head per cycle and compares it against the running max;
//   a beat that fills the last slot passes S_CHECK, S_SCAN and S_EMIT, which
//   loads the result into the output register, and the next input beat is
//   taken in S_IDLE; a supply that leaves slots empty returns there from
//   S_CHECK with no beat, an error goes straight to S_EMIT. One input beat at a time.
// Reset (synchronous, rst_n low): all slots empty, active_lists = 16, no
//   result pending. RAM contents need no clearing.
// Stall: a finished result waits in the output register; the next input is
//   taken only after it has been loaded there.
`timescale 1ns / 1ps
`include "k_way_max_merge_unit_defines.svh"

module k_way_max_merge_unit
  import kwmm_pkg::*;
#(
  parameter int MAX_LISTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LIDX_W-1:0] in_list_index,
  input  logic [VAL_W-1:0]  in_element,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  out_merged_value,
  output logic [LIDX_W-1:0] out_refill_list,
  output logic              out_done_res,
  output logic              out_error,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW    = $clog2(MAX_LISTS);
  localparam int CNT_W = $clog2(MAX_LISTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_EMIT} state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     active_r;
  logic [MAX_LISTS-1:0] present_r;

  // scan pipeline
  logic [CNT_W-1:0]     issue_cnt_r;
  logic                 rd_pend_r;
  logic [IW-1:0]        cmp_idx_r;
  logic [VAL_W-1:0]     rd_data_r;
  logic [VAL_W-1:0]     best_r;
  logic [IW-1:0]        best_idx_r;
  logic                 err_pend_r;

  // output register
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_val_r;
  logic [LIDX_W-1:0]    out_idx_r;
  logic                 out_done_r;
  logic                 out_err_r;

  logic [VAL_W-1:0]     head_mem [MAX_LISTS];

  logic [CNT_W-1:0]     n_live;
  logic [MAX_LISTS-1:0] live_mask;
  logic                 all_full;
  logic [IW-1:0]        in_idx;
  logic                 in_bad;
  logic                 in_fire;
  logic                 mem_we;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic                 slot_free;
  logic                 cfg_we;

  // live list count, capped at the slot count
  always_comb begin
    if (int'(active_r) > MAX_LISTS) begin
      n_live = CNT_W'(MAX_LISTS);
    end else begin
      n_live = CNT_W'(active_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LISTS; i++) begin
      live_mask[i] = (i < int'(n_live));
    end
  end

  assign all_full = &(present_r | ~live_mask);

  // supply check: inactive list or occupied slot
  assign in_idx   = IW'(in_list_index);
  assign in_bad   = (int'(in_list_index) >= int'(n_live)) || present_r[in_idx];
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign mem_we   = in_fire && !in_bad;

  assign rd_en     = (state_r == S_SCAN) && (issue_cnt_r < n_live);
  assign rd_addr   = issue_cnt_r[IW-1:0];
  assign slot_free = !out_valid_r || out_ready;

  // head RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      head_mem[in_idx] <= in_element;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= head_mem[rd_addr];
    end
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_RESET;
      present_r   <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      issue_cnt_r <= '0;
      err_pend_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_pwdata[CFG_W-1:0];
      end
      // drained beat; in S_EMIT the load below takes over
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_bad) begin
              err_pend_r <= 1'b1;
              state_r    <= S_EMIT;
            end else begin
              err_pend_r        <= 1'b0;
              present_r[in_idx] <= 1'b1;
              state_r           <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (all_full) begin
            issue_cnt_r <= '0;
            rd_pend_r   <= 1'b0;
            best_r      <= '0;
            best_idx_r  <= '0;
            state_r     <= S_SCAN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          // issue one read, compare the previous one; strict > keeps lowest index
          rd_pend_r <= rd_en;
          if (rd_en) begin
            issue_cnt_r <= issue_cnt_r + CNT_W'(1);
            cmp_idx_r   <= rd_addr;
          end
          if (rd_pend_r && (rd_data_r > best_r)) begin
            best_r     <= rd_data_r;
            best_idx_r <= cmp_idx_r;
          end
          if (!rd_en && !rd_pend_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_err_r   <= err_pend_r;
            if (err_pend_r) begin
              out_val_r  <= '0;
              out_idx_r  <= '0;
              out_done_r <= 1'b0;
            end else if (best_r == '0) begin
              out_val_r  <= '0;
              out_idx_r  <= '0;
              out_done_r <= 1'b1;
              present_r  <= '0;
            end else begin
              out_val_r             <= best_r;
              out_idx_r             <= LIDX_W'(best_idx_r);
              out_done_r            <= 1'b0;
              present_r[best_idx_r] <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_val_r;
  assign out_refill_list  = out_idx_r;
  assign out_done_res     = out_done_r;
  assign out_error        = out_err_r;

  // APB register access
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == REG_ACTIVE_LISTS);
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_LISTS) ? APB_DW'(active_r) : '0;

  // assertions
  `KWMM_ASSERT_IMP(a_load_from_emit, $rose(out_valid_r), $past(state_r == S_EMIT))
  `KWMM_ASSERT_IMP(a_done_clears, $rose(out_valid_r) && out_done_r, present_r == '0)
  `KWMM_ASSERT_IMP(a_err_fields_zero, out_valid_r && out_err_r,
                   (out_val_r == '0) && (out_idx_r == '0) && !out_done_r)
  `KWMM_ASSERT_IMP(a_refill_cleared, $rose(out_valid_r) && !out_err_r && !out_done_r,
                   !present_r[IW'(out_idx_r)])

endmodule
